/* design/srrw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and codes for the selective-repeat receive window unit.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int SEQ_W   = 4;
  localparam int ADDR_W  = 48;
  localparam int WIN_W   = 4;
  localparam int KIND_W  = 3;
  localparam int REQ_W   = 2;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Frame kinds on the input
  localparam logic [REQ_W-1:0] REQ_DATA = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NAK  = 2'd2;

  localparam logic [WIN_W-1:0] WIN_RESET = 4'd8;

  // Result kinds on the output
  typedef enum logic [KIND_W-1:0] {
    RK_QUEUE_ACK = 3'd0,
    RK_SEND_NAK  = 3'd1,
    RK_DELIVER   = 3'd2,
    RK_ACK_RX    = 3'd3,
    RK_NAK_RX    = 3'd4
  } kind_e;

  // Work the back end carries out for a queued item
  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_ACK_NOTE = 2'd1,
    OP_NAK_NOTE = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] src;
    logic [SEQ_W-1:0]  ackn;
    logic              has_ack;
    logic              seq_lt_m;
  } item_t;

endpackage

/* design/srrw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_front
// Input stage: accept frames, classify them and push work to the queue.
// ----------------------------------------------------------------------------
module srrw_front #(
  parameter int M_W = 5
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [srrw_pkg::REQ_W-1:0]  req_type_i,
  input  logic [srrw_pkg::SEQ_W-1:0]  seq_number_i,
  input  logic [srrw_pkg::ADDR_W-1:0] source_addr_i,
  input  logic [srrw_pkg::SEQ_W-1:0]  ack_number_i,
  input  logic                        has_ack_i,
  input  logic [M_W-1:0]              m_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output srrw_pkg::item_t             item_o
);
  import srrw_pkg::*;

  logic keep;

  always_comb begin
    keep          = 1'b1;
    item_o.op     = OP_DATA;
    unique case (req_type_i)
      REQ_DATA: item_o.op = OP_DATA;
      REQ_ACK:  item_o.op = OP_ACK_NOTE;
      REQ_NAK:  item_o.op = OP_NAK_NOTE;
      default:  keep = 1'b0; // drop unknown frame kinds
    endcase
    item_o.seq      = seq_number_i;
    item_o.src      = source_addr_i;
    item_o.ackn     = ack_number_i;
    item_o.has_ack  = has_ack_i;
    item_o.seq_lt_m = 32'(seq_number_i) < 32'(m_i);
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

/* design/srrw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_queue
// Short FIFO that decouples the classifying front from the window back end.
// ----------------------------------------------------------------------------
module srrw_queue #(
  parameter int TAG_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  srrw_pkg::item_t       item_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output srrw_pkg::item_t       item_o,
  output logic [TAG_BITS-1:0]   tag_o
);
  import srrw_pkg::*;

  item_t               ent_q [Q_DEPTH];
  logic [TAG_BITS-1:0] tag_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0]  cnt_q, cnt_d;
  logic                do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = ent_q[rd_q];
  assign tag_o   = tag_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= item_i;
      tag_q[wr_q] <= tag_i;
    end
  end

endmodule

/* design/srrw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_back
// Window engine: acknowledge, store, deliver in order and notify.
// ----------------------------------------------------------------------------
module srrw_back #(
  parameter int SLOTS    = 16,
  parameter int TAG_BITS = 16,
  parameter int M_W      = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [M_W-1:0]              w_i,
  input  logic [M_W-1:0]              m_i,
  input  logic                        head_valid_i,
  input  srrw_pkg::item_t             head_i,
  input  logic [TAG_BITS-1:0]         head_tag_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srrw_pkg::KIND_W-1:0] result_kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]  number_o,
  output logic [srrw_pkg::ADDR_W-1:0] peer_addr_o,
  output logic [TAG_BITS-1:0]         out_payload_tag_o,
  output logic                        last_o
);
  import srrw_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DELIV = 4'b0100,
    S_PIGGY = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    base_q, base_d;
  logic [SLOTS-1:0]    marks_q;
  logic [TAG_BITS-1:0] tag_mem [SLOTS];
  logic [TAG_BITS-1:0] tag_rd_q;

  logic                out_valid_q, out_valid_d, out_free, load;
  kind_e               kind_q, kind_d;
  logic [SEQ_W-1:0]    num_q, num_d;
  logic [ADDR_W-1:0]   peer_q, peer_d;
  logic [TAG_BITS-1:0] otag_q, otag_d;
  logic                last_q, last_d;

  logic [IDX_W-1:0]    seq_idx, nb_idx;
  logic [M_W-1:0]      seq_m, base_m, off, base_inc;
  logic                in_window, will_deliver, mark_set, mark_clr;

  // Window test and next base
  always_comb begin
    seq_m     = M_W'(head_i.seq);
    base_m    = M_W'(base_q);
    seq_idx   = IDX_W'(head_i.seq);
    off       = (seq_m >= base_m) ? seq_m - base_m : seq_m + m_i - base_m;
    in_window = head_i.seq_lt_m && (off < w_i);
    base_inc  = base_m + 1'b1;
    nb_idx    = (base_inc == m_i) ? '0 : IDX_W'(base_inc);
    // The stored frame lands on the base, or the base was already marked
    will_deliver = (seq_idx == base_q) || marks_q[base_q];
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    mark_set = 1'b0;
    mark_clr = 1'b0;
    kind_d   = RK_ACK_RX;
    num_d    = head_i.ackn;
    peer_d   = head_i.src;
    otag_d   = '0;
    last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i && out_free) begin
          load = 1'b1;
          case (head_i.op)
            OP_ACK_NOTE: begin
              kind_d = RK_ACK_RX;
              pop_o  = 1'b1;
            end
            OP_NAK_NOTE: begin
              kind_d = RK_NAK_RX;
              pop_o  = 1'b1;
            end
            default: begin
              if (in_window) begin
                kind_d   = RK_QUEUE_ACK;
                num_d    = head_i.seq;
                last_d   = !head_i.has_ack && !will_deliver;
                mark_set = !marks_q[seq_idx];
                state_d  = S_WALK;
              end else begin
                kind_d = RK_SEND_NAK;
                num_d  = SEQ_W'(base_q);
                last_d = !head_i.has_ack;
                if (head_i.has_ack) begin
                  state_d = S_PIGGY;
                end else begin
                  pop_o = 1'b1;
                end
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (marks_q[base_q]) begin
          state_d = S_DELIV;
        end else if (head_i.has_ack) begin
          state_d = S_PIGGY;
        end else begin
          pop_o   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DELIV: begin
        if (out_free) begin
          load     = 1'b1;
          kind_d   = RK_DELIVER;
          num_d    = SEQ_W'(base_q);
          peer_d   = '0;
          otag_d   = tag_rd_q;
          last_d   = !head_i.has_ack && !marks_q[nb_idx];
          mark_clr = 1'b1;
          base_d   = nb_idx;
          state_d  = S_WALK;
        end
      end
      S_PIGGY: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = RK_ACK_RX;
          pop_o   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      marks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // restart the window at zero under the new modulus
        base_q  <= '0;
        marks_q <= '0;
      end else begin
        base_q <= base_d;
        if (mark_set) marks_q[seq_idx] <= 1'b1;
        if (mark_clr) marks_q[base_q]  <= 1'b0;
      end
    end
  end

  // Payload tag store, read at the base
  always_ff @(posedge clk_i) begin
    if (mark_set) tag_mem[seq_idx] <= head_tag_i;
    tag_rd_q <= tag_mem[base_q];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      num_q  <= num_d;
      peer_q <= peer_d;
      otag_q <= otag_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign number_o          = num_q;
  assign peer_addr_o       = peer_q;
  assign out_payload_tag_o = otag_q;
  assign last_o            = last_q;

  a_base_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_m < m_i)
    else $error("receive base outside the sequence space");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (base_q == '0) && (marks_q == '0))
    else $error("window not restarted by a configuration write");

  a_idle_base_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !marks_q[base_q])
    else $error("marked slot left at the base between items");

  a_deliver_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (kind_d == RK_DELIVER)) |-> marks_q[base_q])
    else $error("delivery of a slot that never arrived");

endmodule

/* design/selective_repeat_receive_window_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_unit
// Receiver side of a selective-repeat ARQ link with in-order delivery.
// ----------------------------------------------------------------------------
// Takes one received frame per item and returns one or more result items, the
// final one flagged by last_o. ACK and NAK frames come back as one
// notification each. A data frame inside the circular window gives a queue-ack
// result, is stored if new, then every consecutive stored frame from the base
// is delivered in order; a data frame outside the window (or with a sequence
// number at or above twice the window) gives a NAK for the base. A piggybacked
// ack is forwarded as the final result. Unknown frame kinds are accepted and
// dropped with no result. The front stage accepts an item in any cycle the
// two-entry queue has room. In the back end, each frame delivered by an
// in-window data frame takes a step of the delivery walk: a tag store read,
// then the emit. The window register resets to 8 and is clamped to
// 1..MAX_WINDOW; write it only while the unit is idle - a write restarts the
// window at sequence zero and clears all arrival marks. Payload tags need no
// clearing pass.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit #(
  parameter int MAX_WINDOW = 8,
  parameter int TAG_BITS   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: window size
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srrw_pkg::WIN_W-1:0]  cfg_data_i,
  // received frames
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [srrw_pkg::REQ_W-1:0]  req_type_i,
  input  logic [srrw_pkg::SEQ_W-1:0]  seq_number_i,
  input  logic [srrw_pkg::ADDR_W-1:0] source_addr_i,
  input  logic [srrw_pkg::SEQ_W-1:0]  ack_number_i,
  input  logic                        has_ack_i,
  input  logic [TAG_BITS-1:0]         payload_tag_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srrw_pkg::KIND_W-1:0] result_kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]  number_o,
  output logic [srrw_pkg::ADDR_W-1:0] peer_addr_o,
  output logic [TAG_BITS-1:0]         out_payload_tag_o,
  output logic                        last_o
);
  import srrw_pkg::*;

  localparam int SLOTS = 2 * MAX_WINDOW;
  // wide enough for the modulus and for a sequence offset plus the modulus
  localparam int M_W   = $clog2(SLOTS) + 1;

  logic [WIN_W-1:0]    window_q;
  logic                cfg_we;
  logic [M_W-1:0]      w_eff, m_eff;

  logic                push, q_full, q_valid, pop;
  item_t               push_item, head_item;
  logic [TAG_BITS-1:0] head_tag;

  // Always ready: writes must arrive only while the unit is idle; the block does not enforce it
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (cfg_we) begin
      window_q <= cfg_data_i;
    end
  end

  // Clamp the window to 1..MAX_WINDOW; sequence numbers wrap at twice that
  always_comb begin
    if (window_q == '0) begin
      w_eff = M_W'(1);
    end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
      w_eff = M_W'(MAX_WINDOW);
    end else begin
      w_eff = M_W'(window_q);
    end
    m_eff = w_eff << 1;
  end

  srrw_front #(
    .M_W (M_W)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .seq_number_i  (seq_number_i),
    .source_addr_i (source_addr_i),
    .ack_number_i  (ack_number_i),
    .has_ack_i     (has_ack_i),
    .m_i           (m_eff),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  srrw_queue #(
    .TAG_BITS (TAG_BITS)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .tag_i   (payload_tag_i),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .tag_o   (head_tag)
  );

  srrw_back #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS),
    .M_W      (M_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .w_i               (w_eff),
    .m_i               (m_eff),
    .head_valid_i      (q_valid),
    .head_i            (head_item),
    .head_tag_i        (head_tag),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .number_o          (number_o),
    .peer_addr_o       (peer_addr_o),
    .out_payload_tag_o (out_payload_tag_o),
    .last_o            (last_o)
  );

endmodule

/* verif/selective_repeat_receive_window_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_unit_tb
// Self-checking bench for the selective-repeat receive window unit.
// ----------------------------------------------------------------------------
// Starts with a short table of hand-picked frames that covers ack and nak
// notifications, unknown kinds, duplicates, out-of-window and out-of-modulus
// sequence numbers, a full in-order delivery run and window writes at both
// clamp extremes. Random phases follow, one per window setting, with mostly
// in-window data frames so that the window fills, drains and wraps. Every
// accepted frame runs through a local window model, and each result item is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit_tb;
  import srrw_pkg::*;

  localparam int MAX_WIN         = 8;
  localparam int TAG_W           = 16;
  localparam int SLOT_CNT        = 2 * MAX_WIN;
  // Longest back-end walk delivers the whole window for one item, two items queued
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 43;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // One received frame as it is driven onto the input ports
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] src;
    logic [SEQ_W-1:0]  ackn;
    logic              has_ack;
    logic [TAG_W-1:0]  tag;
  } rx_frame_t;

  // One result item as it leaves the block
  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  number;
    logic [ADDR_W-1:0] peer;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } rx_result_t;

  // Directed table row: either a window write or a frame. Rows marked typed
  // carry their single expected result by hand (peer = source, no tag).
  typedef struct packed {
    logic              is_cfg;
    logic [WIN_W-1:0]  cfg_val;
    logic [REQ_W-1:0]  req;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] src;
    logic [SEQ_W-1:0]  ackn;
    logic              has_ack;
    logic [TAG_W-1:0]  tag;
    logic              typed;
    kind_e             exp_kind;
    logic [SEQ_W-1:0]  exp_num;
  } plan_row_t;

  localparam int PLAN_LEN = 26;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // notifications straight after reset, address extremes
    '{1'b0, 4'd0, REQ_ACK, 4'd0, 48'hFFFF_FFFF_FFFF, 4'd15, 1'b0, 16'h0000,
      1'b1, RK_ACK_RX, 4'd15},
    '{1'b0, 4'd0, REQ_NAK, 4'd0, 48'h0000_0000_0000, 4'd0, 1'b1, 16'h0000,
      1'b1, RK_NAK_RX, 4'd0},
    // unknown kind: dropped without a result
    '{1'b0, 4'd0, REQ_UNKNOWN, 4'd5, 48'h1234_5678_9ABC, 4'd3, 1'b1, 16'hFFFF,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // in-window at the base: ack plus immediate delivery
    '{1'b0, 4'd0, REQ_DATA, 4'd0, 48'h0000_0000_0001, 4'd0, 1'b0, 16'hFFFF,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // hole at 1, store 2 with a piggybacked ack
    '{1'b0, 4'd0, REQ_DATA, 4'd2, 48'hA5A5_A5A5_A5A5, 4'd15, 1'b1, 16'h0000,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // duplicate of 2: acked again, stored tag kept
    '{1'b0, 4'd0, REQ_DATA, 4'd2, 48'h5A5A_5A5A_5A5A, 4'd0, 1'b0, 16'h1234,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // fill the hole: delivers 1 and 2
    '{1'b0, 4'd0, REQ_DATA, 4'd1, 48'h0000_0000_0002, 4'd0, 1'b0, 16'h5555,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // one past the window edge: nak for the base
    '{1'b0, 4'd0, REQ_DATA, 4'd11, 48'h8000_0000_0000, 4'd0, 1'b0, 16'h0001,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // fill the far end of the window, then close the gap at the base
    '{1'b0, 4'd0, REQ_DATA, 4'd10, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h00AA,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd9, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h0099,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd8, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h0088,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd7, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h0077,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd6, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h0066,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd5, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h0055,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd4, 48'h0000_0000_0003, 4'd0, 1'b0, 16'h0044,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // longest burst: ack, eight deliveries, piggybacked ack
    '{1'b0, 4'd0, REQ_DATA, 4'd3, 48'h0000_0000_0004, 4'd9, 1'b1, 16'h0033,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // window zero clamps to one: modulus two
    '{1'b1, 4'd0, REQ_DATA, 4'd0, 48'h0, 4'd0, 1'b0, 16'h0000,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd2, 48'h0000_0000_0010, 4'd0, 1'b0, 16'h0002,
      1'b1, RK_SEND_NAK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd15, 48'h0000_0000_0011, 4'd0, 1'b0, 16'h0003,
      1'b1, RK_SEND_NAK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd1, 48'h0000_0000_0012, 4'd0, 1'b0, 16'h0004,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd0, 48'h0000_0000_0013, 4'd12, 1'b1, 16'hC0DE,
      1'b0, RK_QUEUE_ACK, 4'd0},
    // window fifteen clamps to eight
    '{1'b1, 4'd15, REQ_DATA, 4'd0, 48'h0, 4'd0, 1'b0, 16'h0000,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd15, 48'h0000_0000_0020, 4'd0, 1'b0, 16'h0005,
      1'b1, RK_SEND_NAK, 4'd0},
    '{1'b0, 4'd0, REQ_DATA, 4'd7, 48'h0000_0000_0021, 4'd0, 1'b0, 16'hBEEF,
      1'b0, RK_QUEUE_ACK, 4'd0},
    '{1'b0, 4'd0, REQ_ACK, 4'd0, 48'h8000_0000_0000, 4'd0, 1'b0, 16'h0000,
      1'b1, RK_ACK_RX, 4'd0},
    '{1'b0, 4'd0, REQ_NAK, 4'd0, 48'h5555_5555_5555, 4'd15, 1'b0, 16'h0000,
      1'b1, RK_NAK_RX, 4'd15}
  };

  // Clock, reset and ports, all known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [WIN_W-1:0]    cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i    = '0;
  logic [SEQ_W-1:0]    seq_number_i  = '0;
  logic [ADDR_W-1:0]   source_addr_i = '0;
  logic [SEQ_W-1:0]    ack_number_i  = '0;
  logic                has_ack_i     = 1'b0;
  logic [TAG_W-1:0]    payload_tag_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [KIND_W-1:0]   result_kind_o;
  logic [SEQ_W-1:0]    number_o;
  logic [ADDR_W-1:0]   peer_addr_o;
  logic [TAG_W-1:0]    out_payload_tag_o;
  logic                last_o;

  // Local window model
  logic [WIN_W-1:0]    win_reg;
  int unsigned         rx_base;
  logic [SLOT_CNT-1:0] arrived;
  logic [TAG_W-1:0]    slot_tag [SLOT_CNT];

  rx_result_t          step_results [$];   // results of the frame just modeled
  rx_result_t          awaited [$];        // results still owed by the block

  int                  mismatches  = 0;
  int                  cyc         = 0;
  int                  burst_left  = 0;
  int                  tx_mode     = 1;    // 0 back to back, 1 bursts, 2 sparse
  int                  rx_mode     = 1;    // 0 never, 1 random, 2 periodic

  selective_repeat_receive_window_unit #(
    .MAX_WINDOW (MAX_WIN),
    .TAG_BITS   (TAG_W)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .seq_number_i      (seq_number_i),
    .source_addr_i     (source_addr_i),
    .ack_number_i      (ack_number_i),
    .has_ack_i         (has_ack_i),
    .payload_tag_i     (payload_tag_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .number_o          (number_o),
    .peer_addr_o       (peer_addr_o),
    .out_payload_tag_o (out_payload_tag_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effective window: zero reads as one, anything above the maximum clamps
  function automatic int unsigned span();
    if (win_reg == '0) return 1;
    if (win_reg > MAX_WIN) return MAX_WIN;
    return int'(win_reg);
  endfunction

  function automatic rx_result_t make_result(kind_e k, logic [SEQ_W-1:0] n,
                                             logic [ADDR_W-1:0] a,
                                             logic [TAG_W-1:0] t);
    rx_result_t r;
    r.kind   = k;
    r.number = n;
    r.peer   = a;
    r.tag    = t;
    r.last   = 1'b0;
    return r;
  endfunction

  // Advance the window model by one frame and list the results it causes
  function automatic void forecast_frame_results(rx_frame_t f);
    int unsigned w;
    int unsigned m;
    int unsigned b;
    logic        in_win;
    step_results.delete();
    w = span();
    m = 2 * w;
    b = rx_base % m;
    case (f.req)
      REQ_ACK: step_results.push_back(make_result(RK_ACK_RX, f.ackn, f.src, '0));
      REQ_NAK: step_results.push_back(make_result(RK_NAK_RX, f.ackn, f.src, '0));
      REQ_DATA: begin
        in_win = (f.seq < m) && (((f.seq + m - b) % m) < w);
        if (in_win) begin
          step_results.push_back(make_result(RK_QUEUE_ACK, f.seq, f.src, '0));
          // keep the first copy of a slot, drop duplicates
          if (!arrived[f.seq]) begin
            slot_tag[f.seq] = f.tag;
            arrived[f.seq]  = 1'b1;
          end
          // walk consecutive arrivals from the base
          while (arrived[b]) begin
            step_results.push_back(make_result(RK_DELIVER, SEQ_W'(b), '0, slot_tag[b]));
            arrived[b] = 1'b0;
            b = (b + 1) % m;
          end
          rx_base = b;
        end else begin
          step_results.push_back(make_result(RK_SEND_NAK, SEQ_W'(b), f.src, '0));
        end
        if (f.has_ack)
          step_results.push_back(make_result(RK_ACK_RX, f.ackn, f.src, '0));
      end
      default: ;
    endcase
  endfunction

  // Present one frame, hold it until accepted, then log what it should cause
  task automatic send_frame(input rx_frame_t f, input bit typed,
                            input kind_e tk, input logic [SEQ_W-1:0] tn);
    int         gap;
    rx_result_t r;
    if (burst_left == 0) begin
      case (tx_mode)
        0: begin
          gap        = 0;
          burst_left = 1000;
        end
        1: begin
          gap        = $urandom_range(1, 6);
          burst_left = $urandom_range(1, 16);
        end
        default: begin
          gap        = $urandom_range(0, 10);
          burst_left = $urandom_range(1, 3);
        end
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= f.req;
    seq_number_i  <= f.seq;
    source_addr_i <= f.src;
    ack_number_i  <= f.ackn;
    has_ack_i     <= f.has_ack;
    payload_tag_i <= f.tag;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    forecast_frame_results(f);
    if (typed) begin
      r      = make_result(tk, tn, f.src, '0);
      r.last = 1'b1;
      awaited.push_back(r);
    end else begin
      for (int i = 0; i < step_results.size(); i++) begin
        r      = step_results[i];
        r.last = (i == step_results.size() - 1);
        awaited.push_back(r);
      end
    end
  endtask

  // Write the window register once the block has gone quiet
  task automatic write_window(input logic [WIN_W-1:0] v);
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    // an unknown frame may still be in flight with nothing owed
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_reg = v;
    rx_base = 0;
    arrived = '0;
  endtask

  // Stimulus
  initial begin
    rx_frame_t   f;
    int unsigned w;
    int unsigned m;
    int unsigned p;
    int          counted;
    logic [WIN_W-1:0] wv;

    win_reg = WIN_RESET;
    rx_base = 0;
    arrived = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) begin
        write_window(PLAN[i].cfg_val);
      end else begin
        f.req     = PLAN[i].req;
        f.seq     = PLAN[i].seq;
        f.src     = PLAN[i].src;
        f.ackn    = PLAN[i].ackn;
        f.has_ack = PLAN[i].has_ack;
        f.tag     = PLAN[i].tag;
        send_frame(f, PLAN[i].typed, PLAN[i].exp_kind, PLAN[i].exp_num);
      end
    end

    // Random phases, one window setting each; extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       wv = 4'd1;
        1:       wv = 4'd15;
        2:       wv = 4'd0;
        3:       wv = 4'd8;
        4:       wv = 4'd2;
        default: wv = WIN_W'($urandom_range(0, 15));
      endcase
      write_window(wv);
      tx_mode    = ph % 3;
      rx_mode    = $urandom_range(0, 2);
      burst_left = 0;
      counted    = 0;
      while (counted < ITEMS_PER_PHASE) begin
        w = span();
        m = 2 * w;
        p = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       f.src = '1;
          1:       f.src = '0;
          default: f.src = {16'($urandom), 32'($urandom)};
        endcase
        case ($urandom_range(0, 9))
          0:       f.tag = '0;
          1:       f.tag = '1;
          default: f.tag = TAG_W'($urandom);
        endcase
        f.ackn    = SEQ_W'($urandom_range(0, 15));
        f.has_ack = ($urandom_range(0, 3) == 0);
        f.seq     = SEQ_W'($urandom_range(0, 15));
        f.req     = REQ_DATA;
        // mostly frames inside the window so that it fills and wraps
        if (p < 62)
          f.seq = SEQ_W'((rx_base + $urandom_range(0, w - 1)) % m);
        else if (p < 72)
          f.seq = SEQ_W'((rx_base + w + $urandom_range(0, w - 1)) % m);
        else if (p < 80)
          ;
        else if (p < 89)
          f.req = REQ_ACK;
        else if (p < 97)
          f.req = REQ_NAK;
        else
          f.req = REQ_UNKNOWN;
        send_frame(f, 1'b0, RK_QUEUE_ACK, '0);
        if (f.req != REQ_UNKNOWN) counted++;
      end
    end

    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("selective_repeat_receive_window_unit_tb passed");
    else
      $display("selective_repeat_receive_window_unit_tb failed");
    $finish;
  end

  // Result side: check each accepted item, then pick the next stall value
  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: result_kind %0d number %0d", result_kind_o, number_o);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          mismatches++;
        end
        if (number_o !== want.number) begin
          $error("number: expected %0d, got %0d", want.number, number_o);
          mismatches++;
        end
        if (peer_addr_o !== want.peer) begin
          $error("peer_addr: expected %h, got %h", want.peer, peer_addr_o);
          mismatches++;
        end
        if (out_payload_tag_o !== want.tag) begin
          $error("out_payload_tag: expected %h, got %h", want.tag, out_payload_tag_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
    case (rx_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 35);
      default: out_stall_i <= ((cyc % 13) < 5);
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("selective_repeat_receive_window_unit_tb failed");
      $finish;
    end
  end

endmodule

/* files.f */
design/srrw_pkg.sv
design/srrw_front.sv
design/srrw_queue.sv
design/srrw_back.sv
design/selective_repeat_receive_window_unit.sv
verif/selective_repeat_receive_window_unit_tb.sv
